// ===== hw/rtl/htfd_pkg.sv =====
package htfd_pkg;

  // Frame layout
  localparam int unsigned DATA_BYTES = 6;
  localparam logic [2:0]  CRC_POS    = 3'd6;

  // CRC-8, poly 0x31, init 0xFF, MSB first, no final xor
  localparam logic [7:0]  CRC_POLY   = 8'h31;
  localparam logic [7:0]  CRC_INIT   = 8'hFF;

  // Scaling: q = (scale * raw) / 1048, done as ((scale * raw) >> 3) / 131.
  // 1/131 by reciprocal: M = ceil(2^32 / 131); error term 14 * y < 2^32
  // for y < 2^25, so the floor is exact over the whole input range.
  localparam logic [6:0]  HUM_SCALE   = 7'd100;
  localparam logic [7:0]  TEMP_SCALE  = 8'd200;
  localparam logic [24:0] RECIP_M     = 25'd32786010;
  localparam int unsigned RECIP_SHIFT = 32;
  localparam logic [18:0] TEMP_OFFSET = 19'd50000;

  // Queue between front and back
  localparam int unsigned QDEPTH = 2;

  typedef struct packed {
    logic [7:0]  status;
    logic [19:0] hraw;
    logic [19:0] traw;
    logic        crc_err;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// ===== hw/rtl/htfd_front.sv =====
module htfd_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             acc_i,
  input  logic [7:0]       data_byte_i,
  input  logic             frame_start_i,
  output logic             push_o,
  output htfd_pkg::job_t   job_o
);
  import htfd_pkg::*;

  logic [2:0] pos_r, pos_nxt;
  logic [7:0] crc_r, crc_nxt;
  logic [7:0] bytes_r [0:DATA_BYTES-1];

  logic [2:0] pos_eff;
  logic [7:0] crc_base;
  logic       is_data;

  always_comb begin
    pos_eff  = frame_start_i ? 3'd0 : pos_r;
    crc_base = (pos_eff == 3'd0) ? CRC_INIT : crc_r;
    is_data  = (pos_eff < CRC_POS);
    pos_nxt  = pos_r;
    crc_nxt  = crc_r;
    if (acc_i) begin
      if (is_data) begin
        pos_nxt = pos_eff + 3'd1;
        crc_nxt = crc8_update(crc_base, data_byte_i);
      end else begin
        pos_nxt = 3'd0;
        crc_nxt = CRC_INIT;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= 3'd0;
      crc_r <= CRC_INIT;
    end else begin
      pos_r <= pos_nxt;
      crc_r <= crc_nxt;
    end
  end

  // frame byte store, no reset
  always_ff @(posedge clk) begin
    if (acc_i && is_data) begin
      bytes_r[pos_eff] <= data_byte_i;
    end
  end

  assign push_o          = acc_i && !is_data;
  assign job_o.status    = bytes_r[0];
  assign job_o.hraw      = {bytes_r[1], bytes_r[2], bytes_r[3][7:4]};
  assign job_o.traw      = {bytes_r[3][3:0], bytes_r[4], bytes_r[5]};
  assign job_o.crc_err   = (crc_base != data_byte_i);

endmodule

// ===== hw/rtl/htfd_queue.sv =====
module htfd_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push_i,
  input  htfd_pkg::job_t     job_i,
  input  logic               pop_i,
  output htfd_pkg::job_t     job_o,
  output htfd_pkg::q_status_t status_o
);
  import htfd_pkg::*;

  localparam int unsigned PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int unsigned CW = $clog2(QDEPTH + 1);

  job_t          mem_r [0:QDEPTH-1];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    return (p == PW'(QDEPTH - 1)) ? '0 : p + PW'(1);
  endfunction

  always_comb begin
    wr_ptr_nxt = push_i ? ptr_inc(wr_ptr_r) : wr_ptr_r;
    rd_ptr_nxt = pop_i  ? ptr_inc(rd_ptr_r) : rd_ptr_r;
    count_nxt  = count_r;
    case ({push_i, pop_i})
      2'b10:   count_nxt = count_r + CW'(1);
      2'b01:   count_nxt = count_r - CW'(1);
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_i) begin
      mem_r[wr_ptr_r] <= job_i;
    end
  end

  assign job_o          = mem_r[rd_ptr_r];
  assign status_o.full  = (count_r == CW'(QDEPTH));
  assign status_o.empty = (count_r == '0);

endmodule

// ===== hw/rtl/htfd_back.sv =====
module htfd_back (
  input  logic               clk,
  input  logic               rst_n,
  input  htfd_pkg::job_t     job_i,
  input  logic               job_avail_i,
  output logic               pop_o,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [7:0]         out_status_byte,
  output logic               out_calibrated,
  output logic               out_busy_res,
  output logic               out_crc_error,
  output logic [16:0]        out_humidity_milli_pct,
  output logic signed [18:0] out_temperature_milli_c
);
  import htfd_pkg::*;

  logic adv;

  // stage 1: scaled raw values, already divided by 8
  logic        s1_valid_r;
  logic [7:0]  s1_status_r;
  logic        s1_err_r;
  logic [23:0] s1_hy_r;
  logic [24:0] s1_ty_r;
  logic [26:0] h_scaled;
  logic [27:0] t_scaled;

  // stage 2: quotients by 131
  logic        s2_valid_r;
  logic [7:0]  s2_status_r;
  logic        s2_err_r;
  logic [16:0] s2_hq_r;
  logic [17:0] s2_tq_r;
  logic [48:0] h_prod;
  logic [49:0] t_prod;

  // output register
  logic        out_valid_r;
  logic [7:0]  out_status_r;
  logic        out_err_r;
  logic [16:0] out_hum_r;
  logic [18:0] out_temp_r;

  assign adv   = !out_valid_r || !out_stall;
  assign pop_o = adv && job_avail_i;

  assign h_scaled = 27'(job_i.hraw) * 27'(HUM_SCALE);
  assign t_scaled = 28'(job_i.traw) * 28'(TEMP_SCALE);
  assign h_prod   = 49'(s1_hy_r) * 49'(RECIP_M);
  assign t_prod   = 50'(s1_ty_r) * 50'(RECIP_M);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r  <= pop_o;
      s2_valid_r  <= s1_valid_r;
      out_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_status_r  <= job_i.status;
      s1_err_r     <= job_i.crc_err;
      s1_hy_r      <= h_scaled[26:3];
      s1_ty_r      <= t_scaled[27:3];
      s2_status_r  <= s1_status_r;
      s2_err_r     <= s1_err_r;
      s2_hq_r      <= h_prod[RECIP_SHIFT+16:RECIP_SHIFT];
      s2_tq_r      <= t_prod[RECIP_SHIFT+17:RECIP_SHIFT];
      out_status_r <= s2_status_r;
      out_err_r    <= s2_err_r;
      out_hum_r    <= s2_hq_r;
      out_temp_r   <= {1'b0, s2_tq_r} - TEMP_OFFSET;
    end
  end

  assign out_valid               = out_valid_r;
  assign out_status_byte         = out_status_r;
  assign out_calibrated          = out_status_r[3];
  assign out_busy_res            = out_status_r[7];
  assign out_crc_error           = out_err_r;
  assign out_humidity_milli_pct  = out_hum_r;
  assign out_temperature_milli_c = $signed(out_temp_r);

endmodule

// ===== hw/rtl/humidity_temperature_frame_decoder.sv =====
// Path: after the transaction of the CRC byte, a job passes the job queue, stage 1, stage 2 and the output register.
// Throughput: one byte per cycle sustained while in_stall is low; one frame is 7 bytes.
// The input stalls only while the 2-entry job queue between front and back is full.
// Back end is a 3-stage pipeline (scale, reciprocal multiply, offset) moved by out_stall.
// Reset (rst_n, synchronous, active low) clears byte position, CRC (to 0xFF), queue
// pointers and pipeline valids; stored frame bytes and payload registers are not reset.
module humidity_temperature_frame_decoder (
  input  logic               clk,
  input  logic               rst_n,
  // input channel: one frame byte per transaction
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         in_data_byte,
  input  logic               in_frame_start,
  // result channel: one transaction per complete frame
  output logic               out_valid,
  input  logic               out_stall,
  output logic [7:0]         out_status_byte,
  output logic               out_calibrated,
  output logic               out_busy_res,
  output logic               out_crc_error,
  output logic [16:0]        out_humidity_milli_pct,
  output logic signed [18:0] out_temperature_milli_c
);
  import htfd_pkg::*;

  logic      in_acc;
  logic      push;
  logic      pop;
  job_t      job_front;
  job_t      job_head;
  q_status_t q_status;

  // Front takes bytes freely unless the queue cannot take a finished frame.
  assign in_stall = q_status.full;
  assign in_acc   = in_valid && !in_stall;

  // Front: byte position, running CRC and the frame byte store. On the CRC
  // byte it packs status, raw humidity, raw temperature and the CRC check
  // into one job.
  htfd_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .acc_i         (in_acc),
    .data_byte_i   (in_data_byte),
    .frame_start_i (in_frame_start),
    .push_o        (push),
    .job_o         (job_front)
  );

  // Short queue, so a stalled result side does not hold up byte intake
  // until a second finished frame is waiting.
  htfd_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push_i   (push),
    .job_i    (job_front),
    .pop_i    (pop),
    .job_o    (job_head),
    .status_o (q_status)
  );

  // Back: fixed-point conversion to milli-percent and millidegrees.
  htfd_back u_back (
    .clk                     (clk),
    .rst_n                   (rst_n),
    .job_i                   (job_head),
    .job_avail_i             (!q_status.empty),
    .pop_o                   (pop),
    .out_valid               (out_valid),
    .out_stall               (out_stall),
    .out_status_byte         (out_status_byte),
    .out_calibrated          (out_calibrated),
    .out_busy_res            (out_busy_res),
    .out_crc_error           (out_crc_error),
    .out_humidity_milli_pct  (out_humidity_milli_pct),
    .out_temperature_milli_c (out_temperature_milli_c)
  );

  // a finished frame never arrives at a full queue
  a_push_not_full: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !q_status.full)
    else $error("job pushed into full queue");

  // back never pops an empty queue
  a_pop_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !q_status.empty)
    else $error("job popped from empty queue");

  // one job held and another pushed with no pop fills the queue
  a_fill: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop && !q_status.empty && !q_status.full) |=> q_status.full)
    else $error("queue occupancy lost");

  // an empty queue with nothing pushed stays empty
  a_stay_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (q_status.empty && !push) |=> q_status.empty)
    else $error("queue occupancy invented");

endmodule
